[hdl/b24kc_pkg.sv]
// Shared types, constants and lookup functions for the base-24 key codec.
package b24kc_pkg;

  localparam int KEY_DIGITS = 25;
  localparam int RADIX      = 24;
  localparam int CNT_W      = 5;
  localparam int LIMB_W     = 32;
  localparam int NUM_LIMBS  = 4;
  localparam int LIMB_IDX_W = 2;
  localparam int REM_W      = 5;
  localparam int XS_W       = 34;          // (rem:limb) >> 3
  localparam int RCP_SHIFT  = 35;

  localparam logic [CNT_W-1:0] LAST_POS   = CNT_W'(KEY_DIGITS - 1);
  localparam logic [CNT_W-1:0] DIGITS_MAX = CNT_W'(KEY_DIGITS);
  localparam logic [LIMB_IDX_W-1:0] LAST_LIMB = LIMB_IDX_W'(NUM_LIMBS - 1);

  // ceil(2^35 / 3): exact quotient by 3 for any 34-bit dividend below 3*2^32
  localparam logic [XS_W-1:0] DIV3_RCP = 34'h2_AAAA_AAAB;

  localparam logic [7:0] ALPHABET [RADIX] = '{
    "B", "C", "D", "F", "G", "H", "J", "K", "M", "P", "Q", "R",
    "T", "V", "W", "X", "Y", "2", "3", "4", "6", "7", "8", "9"
  };

  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  key_char;
    logic        char_is_last;
    logic [63:0] value_low;
    logic [63:0] value_high;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] decoded_low;
    logic [63:0] decoded_high;
    logic [7:0]  out_char;
    logic [4:0]  char_position;
    logic        run_last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ENC
  } state_t;

  typedef struct packed {
    logic             char_step;   // take one key character
    logic             pad_step;    // scale by 24 for a missing digit
    logic             emit_dec;    // show decoded value, clear decoder
    logic             enc_load;    // load value to encode
    logic             enc_step;    // divide one limb by 24
    logic             enc_first;   // first limb of a digit: remainder starts at 0
    logic             emit_enc;    // show one key character
    logic [CNT_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic digits_full;
  } status_t;

  typedef struct packed {
    logic             hit;
    logic [REM_W-1:0] idx;
  } digit_t;

  function automatic digit_t digit_of(input logic [7:0] ch);
    digit_t d;
    d = '0;
    for (int j = 0; j < RADIX; j++) begin
      if (ALPHABET[j] == ch) begin
        d.hit = 1'b1;
        d.idx = REM_W'(j);
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] char_of(input logic [REM_W-1:0] idx);
    logic [7:0] c;
    c = '0;
    for (int j = 0; j < RADIX; j++) begin
      if (idx == REM_W'(j)) c = ALPHABET[j];
    end
    return c;
  endfunction

endpackage

[hdl/b24kc_ctrl.sv]
// Controller: sequences character intake, zero padding and limb-wise encoding.
module b24kc_ctrl import b24kc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    action,
  input  logic    char_is_last,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t                state, state_next;
  logic [LIMB_IDX_W-1:0] limb, limb_next;
  logic [CNT_W-1:0]      pos, pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      limb  <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      limb  <= limb_next;
      pos   <= pos_next;
    end
  end

  always_comb begin
    state_next = state;
    limb_next  = limb;
    pos_next   = pos;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (action) begin
            state_next = ST_ENC;
            limb_next  = '0;
            pos_next   = LAST_POS;
          end else if (char_is_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (status.digits_full) state_next = ST_IDLE;
      end
      ST_ENC: begin
        limb_next = limb + 1'b1;
        if (limb == LAST_LIMB) begin
          if (pos == '0) state_next = ST_IDLE;
          else           pos_next   = pos - 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.pos = pos;
    busy    = 1'b1;
    case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.char_step = start && !action;
        cmd.enc_load  = start && action;
      end
      ST_PAD: begin
        cmd.pad_step = !status.digits_full;
        cmd.emit_dec = status.digits_full;
      end
      ST_ENC: begin
        cmd.enc_step  = 1'b1;
        cmd.enc_first = (limb == '0);
        cmd.emit_enc  = (limb == LAST_LIMB);
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

[hdl/b24kc_datapath.sv]
// Datapath: 128-bit decode accumulator, limb-serial divide-by-24, result register.
module b24kc_datapath import b24kc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  in_t     item,
  input  cmd_t    cmd,
  output status_t status,
  output logic    result_valid,
  output out_t    result
);

  logic [127:0]      acc, acc_next;
  logic [CNT_W-1:0]  digit_count, digit_count_next;
  logic [127:0]      work;
  logic [REM_W-1:0]  rem;

  digit_t                    dig;
  logic [REM_W-1:0]          mul_in;
  logic [LIMB_W+REM_W-1:0]   x;
  logic [XS_W-1:0]           xs;
  logic [2*XS_W-1:0]         prod;
  logic [LIMB_W-1:0]         q;
  logic [1:0]                r3;
  logic [REM_W-1:0]          rem_next;

  assign status.digits_full = (digit_count >= DIGITS_MAX);

  // accumulator * 24 + digit
  assign dig    = digit_of(item.key_char);
  assign mul_in = cmd.char_step ? dig.idx : '0;

  always_comb begin
    acc_next         = acc;
    digit_count_next = digit_count;
    if (cmd.emit_dec) begin
      acc_next         = '0;
      digit_count_next = '0;
    end else if ((cmd.char_step && dig.hit && !status.digits_full) || cmd.pad_step) begin
      acc_next         = (acc << 4) + (acc << 3) + 128'(mul_in);
      digit_count_next = digit_count + 1'b1;
    end
  end

  // one 32-bit limb of (work / 24): low three bits pass through, rest divided by 3
  assign x        = {(cmd.enc_first ? REM_W'(0) : rem), work[127 -: LIMB_W]};
  assign xs       = x[LIMB_W+REM_W-1:3];
  assign prod     = xs * DIV3_RCP;
  assign q        = prod[RCP_SHIFT +: LIMB_W];
  assign r3       = 2'(xs[1:0] - 2'(q[1:0] * 2'd3));
  assign rem_next = {r3, x[2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      digit_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      acc          <= acc_next;
      digit_count  <= digit_count_next;
      result_valid <= cmd.emit_dec || cmd.emit_enc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      work <= {item.value_high, item.value_low};
    end else if (cmd.enc_step) begin
      work <= {work[127-LIMB_W:0], q};
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_dec) begin
      result.result_kind   <= KIND_DECODE;
      result.decoded_low   <= acc[63:0];
      result.decoded_high  <= acc[127:64];
      result.out_char      <= '0;
      result.char_position <= '0;
      result.run_last      <= 1'b1;
    end else if (cmd.emit_enc) begin
      result.result_kind   <= KIND_ENCODE;
      result.decoded_low   <= '0;
      result.decoded_high  <= '0;
      result.out_char      <= char_of(rem_next);
      result.char_position <= cmd.pos;
      result.run_last      <= (cmd.pos == '0);
    end
  end

endmodule

[hdl/base24_key_codec.sv]
// Top level of the base-24 key codec: controller plus datapath.
//
// Input channel: an item transfers at a rising edge with start high and busy low.
// Results: each is shown for exactly one cycle with result_valid high; the
// receiver takes it at the end of that cycle and cannot stall it.
//
// Decode: one key character per item. An ordinary character does not raise busy,
// so characters can stream back to back. A character marked last raises busy
// while missing digits, up to 25, are padded one at a time and the value is then
// emitted; the decoded value appears on the cycle busy drops.
// Encode: the 128-bit value is divided by 24 one 32-bit limb per cycle through a
// single 34x34 reciprocal multiplier, so each key character takes one pass over
// the 4 limbs. The 25 characters come out position 24 first, and the last
// character shows on the cycle busy drops.
// An encode leaves a partly entered decode key untouched.
// Reset clears the decode accumulator, digit count, controller and strobe.
module base24_key_codec import b24kc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic result_valid,
  output out_t result
);

  cmd_t    cmd;
  status_t status;

  b24kc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (item.action),
    .char_is_last (item.char_is_last),
    .status       (status),
    .busy         (busy),
    .cmd          (cmd)
  );

  b24kc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[hdl/base24_key_codec_checker.sv]
// Port-level checker for the base-24 key codec, bound to the top level.
module base24_key_codec_checker import b24kc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input out_t result
);

  // busy only rises after a transfer
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  a_dec_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == KIND_DECODE) |-> result.run_last && !busy)
    else $error("decode result not final or block still busy");

  a_enc_mid: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == KIND_ENCODE) && !result.run_last
      |-> busy && (result.char_position != '0))
    else $error("encode run ended early");

  a_enc_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == KIND_ENCODE) && result.run_last
      |-> !busy && (result.char_position == '0))
    else $error("final encode character misplaced");

endmodule

bind base24_key_codec base24_key_codec_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

[test/testbench.sv]
// Self-checking testbench for the base-24 key codec: directed and random decode/encode traffic.
module testbench;
  import b24kc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_DECODE = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;
  localparam logic [8*24-1:0] KEY_SET = "BCDFGHJKMPQRTVWXY2346789";
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  item;
  logic result_valid;
  out_t result;

  // codec state as seen by the predictor
  logic [127:0] key_acc;
  int           key_digits;

  out_t results_due[$];
  bit   sender_idles;
  int   items_sent;
  int   keys_decoded;
  int   values_encoded;
  int   results_seen;
  int   mismatches;
  int   stall_cycles;

  base24_key_codec u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] key_letter(input int j);
    return KEY_SET[8*(23-j) +: 8];
  endfunction

  function automatic int letter_value(input logic [7:0] c);
    int v;
    v = -1;
    for (int j = 0; j < 24; j++) begin
      if (key_letter(j) == c) v = j;
    end
    return v;
  endfunction

  task automatic predict_codec(input in_t it);
    out_t         r;
    logic [127:0] v;
    int           d;
    if (it.action == ACT_ENCODE) begin
      v = {it.value_high, it.value_low};
      for (int k = 0; k < KEY_DIGITS; k++) begin
        r = '0;
        r.result_kind   = KIND_ENCODE;
        r.out_char      = key_letter(int'(v % 128'd24));
        r.char_position = 5'(KEY_DIGITS - 1 - k);
        r.run_last      = (k == KEY_DIGITS - 1);
        results_due.push_back(r);
        v = v / 128'd24;
      end
      values_encoded++;
    end else begin
      d = letter_value(it.key_char);
      if (d >= 0 && key_digits < KEY_DIGITS) begin
        key_acc = key_acc * 128'd24 + 128'(d);
        key_digits++;
      end
      if (it.char_is_last) begin
        // short key: pad with zero digits
        while (key_digits < KEY_DIGITS) begin
          key_acc = key_acc * 128'd24;
          key_digits++;
        end
        r = '0;
        r.result_kind  = KIND_DECODE;
        r.decoded_low  = key_acc[63:0];
        r.decoded_high = key_acc[127:64];
        r.run_last     = 1'b1;
        results_due.push_back(r);
        key_acc    = '0;
        key_digits = 0;
        keys_decoded++;
      end
    end
  endtask

  // Drive one item; start stays high if the next item follows with no gap.
  task automatic send_item(input in_t it);
    while (sender_idles && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    predict_codec(it);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    in_t it;
    it.action       = ACT_DECODE;
    it.key_char     = c;
    it.char_is_last = last;
    it.value_low    = {$urandom, $urandom};
    it.value_high   = {$urandom, $urandom};
    send_item(it);
  endtask

  task automatic send_value(input logic [63:0] lo, input logic [63:0] hi);
    in_t it;
    it.action       = ACT_ENCODE;
    it.key_char     = 8'($urandom);
    it.char_is_last = 1'($urandom);
    it.value_low    = lo;
    it.value_high   = hi;
    send_item(it);
  endtask

  // Key of ndig random letters in dash-separated groups, with optional noise.
  task automatic send_key(input int ndig, input int noise_pct);
    bit tail;
    tail = (ndig == 0) || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < ndig; i++) begin
      if (i > 0 && i % 5 == 0 && $urandom_range(0, 3) != 0) send_char("-", 1'b0);
      if ($urandom_range(0, 99) < noise_pct) send_char(8'($urandom), 1'b0);
      send_char(key_letter($urandom_range(0, 23)), !tail && i == ndig - 1);
    end
    if (tail) send_char($urandom_range(0, 1) ? 8'("-") : 8'($urandom), 1'b1);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic test_encode_extremes();
    send_value('0, '0);
    send_value('1, '1);
    send_value(64'd1, '0);
    send_value('0, 64'h8000_0000_0000_0000);
    send_value(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    wait_results_drained();
  endtask

  task automatic test_short_keys();
    send_char("9", 1'b1);          // single digit, rest padded
    send_char("B", 1'b0);
    send_char("-", 1'b1);          // dash marked last still ends the key
    send_char("b", 1'b1);          // lowercase is foreign: empty key
    send_char("Q", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("2", 1'b0);
    send_char(8'h00, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_encode_inside_key();
    send_char("7", 1'b0);
    send_char("K", 1'b0);
    send_value({$urandom, $urandom}, {$urandom, $urandom});
    send_char("X", 1'b0);
    send_char("-", 1'b0);
    send_char("M", 1'b1);
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    sender_idles = 1'b0;
    for (int i = 0; i < KEY_DIGITS; i++) send_char("9", i == KEY_DIGITS - 1);
    send_value({$urandom, $urandom}, {$urandom, $urandom});
    send_key(KEY_DIGITS + 3, 0);   // excess digits are dropped
    sender_idles = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < 70) begin
      if ($urandom_range(0, 99) < 20) begin
        case ($urandom_range(0, 3))
          0: send_value('0, '0);
          1: send_value({$urandom, $urandom}, '0);
          default: send_value({$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end else begin
        send_key($urandom_range(0, 1) ? KEY_DIGITS : $urandom_range(0, 30), 10);
      end
      if ($urandom_range(0, 9) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  task automatic check_field(input string name, input logic [127:0] want,
                             input logic [127:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, result);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 128'(want.result_kind), 128'(result.result_kind));
        check_field("decoded_low", 128'(want.decoded_low), 128'(result.decoded_low));
        check_field("decoded_high", 128'(want.decoded_high), 128'(result.decoded_high));
        check_field("out_char", 128'(want.out_char), 128'(result.out_char));
        check_field("char_position", 128'(want.char_position),
                    128'(result.char_position));
        check_field("run_last", 128'(want.run_last), 128'(result.run_last));
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[base24_key_codec] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    key_acc      = '0;
    key_digits   = 0;
    sender_idles = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_extremes();
    test_short_keys();
    test_encode_inside_key();
    test_back_to_back();
    test_random_traffic();

    repeat (40) @(posedge clk);
    @(negedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      mismatches++;
    end
    $display("Sent %0d items: %0d keys decoded, %0d values encoded.",
             items_sent, keys_decoded, values_encoded);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[base24_key_codec] OK");
    end else begin
      $display("[base24_key_codec] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/b24kc_pkg.sv
hdl/b24kc_ctrl.sv
hdl/b24kc_datapath.sv
hdl/base24_key_codec.sv
hdl/base24_key_codec_checker.sv
test/testbench.sv
